// File: rtl/core/assert_macros.svh
// Shared assertion shorthands; clk and rst_n come from the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/rde_pkg.sv
package rde_pkg;

  // Default header size in bytes
  localparam int HEADER_BYTES_DEF = 8;

  // Register reset values
  localparam logic [15:0] MAX_PAYLOAD_RST    = 16'd1024;
  localparam logic [15:0] DATAGRAM_LIMIT_RST = 16'd1032;
  localparam logic [31:0] ACK_TIMEOUT_RST    = 32'd1000;

  // Register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_MAX_PAYLOAD    = 2'd0;
  localparam cfg_idx_t CFG_DATAGRAM_LIMIT = 2'd1;
  localparam cfg_idx_t CFG_ACK_TIMEOUT    = 2'd2;

  typedef enum logic [1:0] {
    OP_RX_HEADER  = 2'd0,
    OP_SEND_REL   = 2'd1,
    OP_SEND_UNREL = 2'd2,
    OP_TICK       = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    ACT_NONE           = 5'd0,
    ACT_SHORT          = 5'd1,
    ACT_CONTROL        = 5'd2,
    ACT_TOO_LONG       = 5'd3,
    ACT_UNREL_DELIVER  = 5'd4,
    ACT_UNREL_STALE    = 5'd5,
    ACT_ACK_STALE      = 5'd6,
    ACT_SEND_NEXT      = 5'd7,
    ACT_SEND_DONE      = 5'd8,
    ACT_DUPLICATE      = 5'd9,
    ACT_FRAG_STORED    = 5'd10,
    ACT_MSG_COMPLETE   = 5'd11,
    ACT_SENT           = 5'd12,
    ACT_BUSY_REFUSED   = 5'd13,
    ACT_RESENT         = 5'd14,
    ACT_UNREL_SENT     = 5'd15,
    ACT_UNREL_REFUSED  = 5'd16,
    ACT_BACKUP_IGNORED = 5'd17
  } action_t;

  typedef struct packed {
    logic [15:0] max_payload;
    logic [15:0] datagram_limit;
    logic [31:0] ack_timeout;
  } cfg_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] received_bytes;
    logic [15:0] header_length;
    logic        flag_control;
    logic        flag_backup;
    logic        flag_unreliable;
    logic        flag_acknowledge;
    logic        flag_reliable;
    logic        flag_end_of_message;
    logic [31:0] sequence_in;
    logic [23:0] send_length;
  } item_t;

  typedef struct packed {
    action_t     action;
    logic [31:0] sequence_out;
    logic [15:0] payload_bytes;
    logic        end_of_message_out;
    logic [23:0] message_bytes;
    logic [31:0] dropped_count;
    logic        sender_free;
  } result_t;

  typedef struct packed {
    logic        eom;
    logic [15:0] len;
  } frag_t;

  // Next fragment out of the bytes still to send
  function automatic frag_t frag_len(input logic [23:0] rem, input logic [15:0] mp);
    frag_t f;
    if (rem <= {8'd0, mp}) begin
      f.eom = 1'b1;
      f.len = rem[15:0];
    end else begin
      f.eom = 1'b0;
      f.len = mp;
    end
    return f;
  endfunction

endpackage

// File: rtl/core/rde_cfg_regs.sv
module rde_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  rde_pkg::cfg_idx_t cfg_index,
  input  logic [31:0]       cfg_data,
  output rde_pkg::cfg_t     cfg
);
  import rde_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg      = cfg_r;

  // Register file; an index past the list is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_payload    <= MAX_PAYLOAD_RST;
      cfg_r.datagram_limit <= DATAGRAM_LIMIT_RST;
      cfg_r.ack_timeout    <= ACK_TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_PAYLOAD:    cfg_r.max_payload    <= cfg_data[15:0];
        CFG_DATAGRAM_LIMIT: cfg_r.datagram_limit <= cfg_data[15:0];
        CFG_ACK_TIMEOUT:    cfg_r.ack_timeout    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/rde_engine.sv
module rde_engine #(
  parameter int HEADER_BYTES = rde_pkg::HEADER_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  rde_pkg::cfg_t    cfg,
  input  rde_pkg::item_t   item,
  input  logic             go,
  output rde_pkg::result_t res
);
  import rde_pkg::*;

  localparam logic [15:0] HDR = 16'(HEADER_BYTES);

  // Link state
  logic [31:0] send_seq_r, send_seq_nxt;
  logic [31:0] recv_seq_r, recv_seq_nxt;
  logic [31:0] unrel_send_seq_r, unrel_send_seq_nxt;
  logic [31:0] unrel_recv_seq_r, unrel_recv_seq_nxt;
  logic [23:0] send_rem_r, send_rem_nxt;
  logic [23:0] reasm_r, reasm_nxt;
  logic        idle_r, idle_nxt;
  logic [31:0] ticks_r, ticks_nxt;

  logic [15:0] mp;
  logic [15:0] plen;
  logic [23:0] rem_after_ack;
  logic [24:0] reasm_sum;
  logic [23:0] reasm_sat;
  logic [31:0] ticks_inc;
  frag_t       frag_new, frag_cur, frag_ack;

  // Shared datapath terms
  always_comb begin
    mp            = (cfg.max_payload == 16'd0) ? 16'd1 : cfg.max_payload;
    plen          = (item.header_length >= HDR) ? item.header_length - HDR : 16'd0;
    rem_after_ack = (send_rem_r > {8'd0, mp}) ? send_rem_r - {8'd0, mp} : 24'd0;
    reasm_sum     = {1'b0, reasm_r} + {9'd0, plen};
    reasm_sat     = reasm_sum[24] ? {24{1'b1}} : reasm_sum[23:0];
    ticks_inc     = (&ticks_r) ? ticks_r : ticks_r + 32'd1;
    frag_new      = frag_len(item.send_length, mp);
    frag_cur      = frag_len(send_rem_r, mp);
    frag_ack      = frag_len(rem_after_ack, mp);
  end

  // Decision and next state
  always_comb begin
    send_seq_nxt       = send_seq_r;
    recv_seq_nxt       = recv_seq_r;
    unrel_send_seq_nxt = unrel_send_seq_r;
    unrel_recv_seq_nxt = unrel_recv_seq_r;
    send_rem_nxt       = send_rem_r;
    reasm_nxt          = reasm_r;
    idle_nxt           = idle_r;
    ticks_nxt          = ticks_r;
    res                = '0;
    res.action         = ACT_NONE;

    unique case (item.op)
      OP_RX_HEADER: begin
        priority if (item.received_bytes < HDR) begin
          res.action = ACT_SHORT;
        end else if (item.flag_control) begin
          res.action = ACT_CONTROL;
        end else if (item.header_length > cfg.datagram_limit) begin
          res.action = ACT_TOO_LONG;
        end else if (item.flag_backup) begin
          res.action = ACT_BACKUP_IGNORED;
        end else if (item.flag_unreliable) begin
          if (item.sequence_in < unrel_recv_seq_r) begin
            res.action = ACT_UNREL_STALE;
          end else begin
            res.dropped_count  = item.sequence_in - unrel_recv_seq_r;
            unrel_recv_seq_nxt = item.sequence_in + 32'd1;
            res.payload_bytes  = plen;
            res.action         = ACT_UNREL_DELIVER;
          end
        end else if (item.flag_acknowledge) begin
          if (idle_r || item.sequence_in != send_seq_r - 32'd1) begin
            res.action = ACT_ACK_STALE;
          end else begin
            send_rem_nxt = rem_after_ack;
            if (rem_after_ack != 24'd0) begin
              res.payload_bytes      = frag_ack.len;
              res.end_of_message_out = frag_ack.eom;
              res.sequence_out       = send_seq_r;
              send_seq_nxt           = send_seq_r + 32'd1;
              ticks_nxt              = 32'd0;
              res.action             = ACT_SEND_NEXT;
            end else begin
              idle_nxt   = 1'b1;
              res.action = ACT_SEND_DONE;
            end
          end
        end else if (item.flag_reliable) begin
          res.sequence_out = item.sequence_in;
          if (item.sequence_in != recv_seq_r) begin
            res.action = ACT_DUPLICATE;
          end else begin
            recv_seq_nxt      = recv_seq_r + 32'd1;
            res.payload_bytes = plen;
            if (item.flag_end_of_message) begin
              res.message_bytes = reasm_sat;
              reasm_nxt         = 24'd0;
              res.action        = ACT_MSG_COMPLETE;
            end else begin
              reasm_nxt  = reasm_sat;
              res.action = ACT_FRAG_STORED;
            end
          end
        end else begin
          res.action = ACT_NONE;
        end
      end
      OP_SEND_REL: begin
        if (!idle_r) begin
          res.action = ACT_BUSY_REFUSED;
        end else begin
          send_rem_nxt           = item.send_length;
          res.payload_bytes      = frag_new.len;
          res.end_of_message_out = frag_new.eom;
          res.sequence_out       = send_seq_r;
          send_seq_nxt           = send_seq_r + 32'd1;
          idle_nxt               = 1'b0;
          ticks_nxt              = 32'd0;
          res.action             = ACT_SENT;
        end
      end
      OP_SEND_UNREL: begin
        if (item.send_length >= {8'd0, mp}) begin
          res.action = ACT_UNREL_REFUSED;
        end else begin
          res.sequence_out   = unrel_send_seq_r;
          unrel_send_seq_nxt = unrel_send_seq_r + 32'd1;
          res.payload_bytes  = item.send_length[15:0];
          res.action         = ACT_UNREL_SENT;
        end
      end
      OP_TICK: begin
        // Count only while a fragment awaits its ack
        if (!idle_r) begin
          if (ticks_inc > cfg.ack_timeout) begin
            res.payload_bytes      = frag_cur.len;
            res.end_of_message_out = frag_cur.eom;
            res.sequence_out       = send_seq_r - 32'd1;
            ticks_nxt              = 32'd0;
            res.action             = ACT_RESENT;
          end else begin
            ticks_nxt = ticks_inc;
          end
        end
      end
      default: ;
    endcase

    res.sender_free = idle_nxt;
  end

  // State update on each processed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      send_seq_r       <= '0;
      recv_seq_r       <= '0;
      unrel_send_seq_r <= '0;
      unrel_recv_seq_r <= '0;
      send_rem_r       <= '0;
      reasm_r          <= '0;
      idle_r           <= 1'b1;
      ticks_r          <= '0;
    end else if (go) begin
      send_seq_r       <= send_seq_nxt;
      recv_seq_r       <= recv_seq_nxt;
      unrel_send_seq_r <= unrel_send_seq_nxt;
      unrel_recv_seq_r <= unrel_recv_seq_nxt;
      send_rem_r       <= send_rem_nxt;
      reasm_r          <= reasm_nxt;
      idle_r           <= idle_nxt;
      ticks_r          <= ticks_nxt;
    end
  end

endmodule

// File: rtl/core/reliable_datagram_endpoint.sv
// Channel  Direction  Handshake           Carries
// in_      in         in_valid/in_stall   one request: header, send or tick
// out_     out        out_valid/out_stall one result per request
// cfg_     in         cfg_valid/cfg_ready register index and write data
//
// One request per cycle sustained while out_stall is low; a request passes through the
// input register, then decision logic into the result register.
// Link state updates in the cycle a request moves into the result register.
// Synchronous active-low reset; first request may be taken in the next cycle.
// out_stall holds the result register and backs up into in_stall that cycle.
module reliable_datagram_endpoint #(
  parameter int HEADER_BYTES = rde_pkg::HEADER_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_op,
  input  logic [15:0]       in_received_bytes,
  input  logic [15:0]       in_header_length,
  input  logic              in_flag_control,
  input  logic              in_flag_backup,
  input  logic              in_flag_unreliable,
  input  logic              in_flag_acknowledge,
  input  logic              in_flag_reliable,
  input  logic              in_flag_end_of_message,
  input  logic [31:0]       in_sequence_in,
  input  logic [23:0]       in_send_length,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [4:0]        out_action,
  output logic [31:0]       out_sequence_out,
  output logic [15:0]       out_payload_bytes,
  output logic              out_end_of_message_out,
  output logic [23:0]       out_message_bytes,
  output logic [31:0]       out_dropped_count,
  output logic              out_sender_free,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  rde_pkg::cfg_idx_t cfg_index,
  input  logic [31:0]       cfg_data
);
  import rde_pkg::*;

  cfg_t    cfg;
  item_t   item_r;
  logic    in_valid_r;
  result_t res, res_r;
  logic    out_valid_r;
  logic    advance, go, in_accept;

  rde_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Flow control
  assign advance   = !out_valid_r || !out_stall;
  assign go        = in_valid_r && advance;
  assign in_stall  = in_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r.op                  <= op_t'(in_op);
      item_r.received_bytes      <= in_received_bytes;
      item_r.header_length       <= in_header_length;
      item_r.flag_control        <= in_flag_control;
      item_r.flag_backup         <= in_flag_backup;
      item_r.flag_unreliable     <= in_flag_unreliable;
      item_r.flag_acknowledge    <= in_flag_acknowledge;
      item_r.flag_reliable       <= in_flag_reliable;
      item_r.flag_end_of_message <= in_flag_end_of_message;
      item_r.sequence_in         <= in_sequence_in;
      item_r.send_length         <= in_send_length;
    end
  end

  rde_engine #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .item  (item_r),
    .go    (go),
    .res   (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= go;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res_r <= res;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_action             = res_r.action;
  assign out_sequence_out       = res_r.sequence_out;
  assign out_payload_bytes      = res_r.payload_bytes;
  assign out_end_of_message_out = res_r.end_of_message_out;
  assign out_message_bytes      = res_r.message_bytes;
  assign out_dropped_count      = res_r.dropped_count;
  assign out_sender_free        = res_r.sender_free;

endmodule

// File: rtl/core/rde_checker.sv
`include "assert_macros.svh"

module rde_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [4:0]  out_action,
  input logic [31:0] out_sequence_out,
  input logic [15:0] out_payload_bytes,
  input logic        out_end_of_message_out,
  input logic        out_sender_free
);
  import rde_pkg::*;

  // A stalled result stays put
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_action) && $stable(out_sequence_out), "stalled result changed")

  // A busy-refused or empty result carries no transfer
  `ASSERT_IMPL(a_none_empty, out_valid && (out_action == ACT_NONE || out_action == ACT_BUSY_REFUSED), out_sequence_out == 32'd0 && out_payload_bytes == 16'd0, "empty result carries data")

  // A fresh send always leaves the sender busy
  `ASSERT_IMPL(a_sent_busy, out_valid && out_action == ACT_SENT, !out_sender_free, "sender free after send")

  // Sender is released only when the last ack lands
  `ASSERT_IMPL(a_done_free, out_valid && out_action == ACT_SEND_DONE, out_sender_free, "sender busy after completion")

  // End-of-message flag only on reliable transmissions
  `ASSERT_IMPL(a_eom_tx, out_valid && out_end_of_message_out, out_action == ACT_SENT || out_action == ACT_SEND_NEXT || out_action == ACT_RESENT, "end flag on non-transmit")

endmodule

bind reliable_datagram_endpoint rde_checker u_rde_checker (.*);
